FILE: hw/rtl/olir_pkg.sv
// Ordered list insert/remove: shared types and field widths.
// Used by the interfaces, the cells, the controller and the top level.
`default_nettype none

package olir_pkg;

	localparam int KIND_W   = 3;
	localparam int INDEX_W  = 4;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// Request kinds; the three codes above remove-by-value are ignored.
	typedef enum logic [KIND_W-1:0] {
		KIND_READ       = 3'd0,
		KIND_WRITE      = 3'd1,
		KIND_INSERT     = 3'd2,
		KIND_REMOVE_AT  = 3'd3,
		KIND_REMOVE_VAL = 3'd4
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK       = 2'd0,
		STATUS_RANGE    = 2'd1,
		STATUS_FULL     = 2'd2,
		STATUS_NOTFOUND = 2'd3
	} status_t;

	// Broadcast from the controller to every cell of the row.
	typedef struct packed {
		logic               load_at;       // load the request word at index
		logic               shift_up;      // cells above index take lower neighbor
		logic               shift_down_at; // cells at/above index take upper neighbor
		logic               remove_val;    // cells at/after first match take upper neighbor
		logic [INDEX_W-1:0] index;
	} row_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/olir_in_if.sv
// Request channel of the ordered list: valid/ready plus request fields.
// Depends on olir_pkg for field widths.
`default_nettype none

interface olir_in_if;
	logic                          valid;
	logic                          ready;
	logic [olir_pkg::KIND_W-1:0]   kind;
	logic [olir_pkg::INDEX_W-1:0]  index;
	logic [olir_pkg::VALUE_W-1:0]  value;

	modport source (output valid, output kind, output index, output value, input ready);
	modport sink   (input valid, input kind, input index, input value, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/olir_out_if.sv
// Result channel of the ordered list: valid/ready plus result fields.
// Depends on olir_pkg for field widths.
`default_nettype none

interface olir_out_if;
	logic                          valid;
	logic                          ready;
	logic [olir_pkg::STATUS_W-1:0] status;
	logic [olir_pkg::VALUE_W-1:0]  data;
	logic [olir_pkg::COUNT_W-1:0]  count;

	modport source (output valid, output status, output data, output count, input ready);
	modport sink   (input valid, input status, input data, input count, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/olir_cell.sv
// One list position: holds one entry and trades it with its neighbors.
// Depends on olir_pkg (row_ctl_t).
`default_nettype none

module olir_cell #(
	parameter int POS        = 0,
	parameter int DATA_WIDTH = 32,
	parameter int CNT_W      = 5
) (
	input  wire                     clk,
	input  wire  olir_pkg::row_ctl_t ctl,
	input  wire  [DATA_WIDTH-1:0]   value_w,
	input  wire  [CNT_W-1:0]        count,
	input  wire  [DATA_WIDTH-1:0]   lower_word,
	input  wire  [DATA_WIDTH-1:0]   upper_word,
	input  wire                     found_in,
	input  wire  [DATA_WIDTH-1:0]   rd_in,
	output logic [DATA_WIDTH-1:0]   word,
	output logic                    found_out,
	output logic [DATA_WIDTH-1:0]   rd_out
);

	logic [DATA_WIDTH-1:0] entry_q;
	logic [DATA_WIDTH-1:0] entry_d;
	logic                  occupied;
	logic                  at_idx;
	logic                  above_idx;

	assign occupied  = CNT_W'(POS) < count;
	assign at_idx    = 32'(ctl.index) == 32'(POS);
	assign above_idx = 32'(POS) > 32'(ctl.index);

	// first-match chain: once a match is seen, every later cell closes the gap
	assign found_out = found_in | (occupied & (entry_q == value_w));
	assign rd_out    = rd_in | (at_idx ? entry_q : '0);
	assign word      = entry_q;

	always_comb begin
		entry_d = entry_q;
		if (ctl.shift_up && above_idx) begin
			entry_d = lower_word;
		end else if (ctl.load_at && at_idx) begin
			entry_d = value_w;
		end else if (ctl.shift_down_at && (at_idx || above_idx)) begin
			entry_d = upper_word;
		end else if (ctl.remove_val && found_out) begin
			entry_d = upper_word;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

`default_nettype wire

FILE: hw/rtl/olir_ctrl.sv
// Request decode: range checks, status, next length and row control.
// Depends on olir_pkg (kind_t, status_t, row_ctl_t).
`default_nettype none

module olir_ctrl #(
	parameter int CAPACITY = 16,
	parameter int CNT_W    = 5
) (
	input  wire                             accept,
	input  wire  [olir_pkg::KIND_W-1:0]     kind,
	input  wire  [olir_pkg::INDEX_W-1:0]    index,
	input  wire  [CNT_W-1:0]                count,
	input  wire                             found,
	output olir_pkg::row_ctl_t              ctl,
	output olir_pkg::status_t               status,
	output logic                            data_from_row,
	output logic                            data_from_value,
	output logic [CNT_W-1:0]                count_d
);

	localparam int CMP_W = (CNT_W > olir_pkg::INDEX_W) ? CNT_W : olir_pkg::INDEX_W;

	logic [CMP_W-1:0] idx_c;
	logic [CMP_W-1:0] cnt_c;
	logic             in_range;
	logic             ins_ok;
	logic             full;

	assign idx_c    = CMP_W'(index);
	assign cnt_c    = CMP_W'(count);
	assign in_range = idx_c < cnt_c;
	assign ins_ok   = idx_c <= cnt_c;
	assign full     = count == CNT_W'(CAPACITY);

	always_comb begin
		ctl             = '0;
		ctl.index       = index;
		status          = olir_pkg::STATUS_OK;
		data_from_row   = 1'b0;
		data_from_value = 1'b0;
		count_d         = count;
		unique case (olir_pkg::kind_t'(kind))
			olir_pkg::KIND_READ: begin
				if (in_range) data_from_row = 1'b1;
				else          status = olir_pkg::STATUS_RANGE;
			end
			olir_pkg::KIND_WRITE: begin
				if (in_range) ctl.load_at = accept;
				else          status = olir_pkg::STATUS_RANGE;
			end
			olir_pkg::KIND_INSERT: begin
				if (full) begin
					status = olir_pkg::STATUS_FULL;
				end else if (!ins_ok) begin
					status = olir_pkg::STATUS_RANGE;
				end else begin
					ctl.load_at  = accept;
					ctl.shift_up = accept;
					count_d      = count + 1'b1;
				end
			end
			olir_pkg::KIND_REMOVE_AT: begin
				if (in_range) begin
					ctl.shift_down_at = accept;
					data_from_row     = 1'b1;
					count_d           = count - 1'b1;
				end else begin
					status = olir_pkg::STATUS_RANGE;
				end
			end
			olir_pkg::KIND_REMOVE_VAL: begin
				// no cell moves unless some occupied cell matched
				ctl.remove_val = accept;
				if (found) begin
					data_from_value = 1'b1;
					count_d         = count - 1'b1;
				end else begin
					status = olir_pkg::STATUS_NOTFOUND;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: hw/rtl/ordered_list_insert_remove_top.sv
// Ordered list insert/remove, top level: cell row, controller, result register.
// Depends on olir_pkg, olir_in_if, olir_out_if, olir_cell and olir_ctrl.
`default_nettype none

// Fixed-capacity ordered list of words held in a row of CAPACITY cells, one
// entry per cell. Each request (read, write, insert at index, remove at index,
// remove first equal value) completes in the cycle it is accepted: every cell
// decides from the broadcast request and its own position whether to hold,
// load the request word, take its lower neighbor (insert) or take its upper
// neighbor (removal), so the whole list shifts together at the clock edge. Remove by
// value finds the first match through a found chain that runs from cell 0
// upward, and a read gathers its word through a select chain along the row.
// One item is taken per cycle; the result sits in an output register, and a
// new item is accepted whenever that register is empty or being drained in
// the same cycle, so a result that is not yet taken stalls only the next
// request. There is no clearing pass after reset: only the length is cleared,
// and an entry is read only once it lies below the length. The count field is
// the length after the request, carried in the count field of the result port.
module ordered_list_insert_remove_top #(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32
) (
	input wire         clk,
	input wire         arst_n,
	olir_in_if.sink    req,
	olir_out_if.source rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int VW    = olir_pkg::VALUE_W;
	localparam int CW    = olir_pkg::COUNT_W;

	// list state
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_d;

	// cell row wiring: each index is one fixed cell
	logic [DATA_WIDTH-1:0] cell_word  [CAPACITY];
	logic                  found_chain[CAPACITY+1];
	logic [DATA_WIDTH-1:0] rd_chain   [CAPACITY+1];

	logic                  req_fire;
	logic [DATA_WIDTH-1:0] value_w;
	logic [DATA_WIDTH-1:0] data_w;
	olir_pkg::row_ctl_t    ctl;
	olir_pkg::status_t     status_d;
	logic                  data_from_row;
	logic                  data_from_value;

	// result register
	logic                            rsp_valid_q;
	logic [olir_pkg::STATUS_W-1:0]   rsp_status_q;
	logic [VW-1:0]                   rsp_data_q;
	logic [CW-1:0]                   rsp_count_q;
	logic [VW-1:0]                   rsp_data_d;
	logic [CW-1:0]                   rsp_count_d;

	// accept while the result slot is empty or draining this cycle
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign req_fire  = req.valid && req.ready;

	// fit the request word to the stored width
	generate
		if (DATA_WIDTH <= VW) begin : g_val_narrow
			assign value_w    = req.value[DATA_WIDTH-1:0];
			assign rsp_data_d = VW'(data_w);
		end else begin : g_val_wide
			assign value_w    = {{(DATA_WIDTH-VW){1'b0}}, req.value};
			assign rsp_data_d = data_w[VW-1:0];
		end
		if (CNT_W >= CW) begin : g_cnt_narrow
			assign rsp_count_d = count_d[CW-1:0];
		end else begin : g_cnt_wide
			assign rsp_count_d = CW'(count_d);
		end
	endgenerate

	assign found_chain[0] = 1'b0;
	assign rd_chain[0]    = '0;

	generate
		for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
			olir_cell #(
				.POS        (g),
				.DATA_WIDTH (DATA_WIDTH),
				.CNT_W      (CNT_W)
			) u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.value_w    (value_w),
				.count      (count_q),
				.lower_word (cell_word[(g == 0) ? 0 : g - 1]),
				.upper_word (cell_word[(g == CAPACITY - 1) ? g : g + 1]),
				.found_in   (found_chain[g]),
				.rd_in      (rd_chain[g]),
				.word       (cell_word[g]),
				.found_out  (found_chain[g + 1]),
				.rd_out     (rd_chain[g + 1])
			);
		end
	endgenerate

	olir_ctrl #(
		.CAPACITY (CAPACITY),
		.CNT_W    (CNT_W)
	) u_ctrl (
		.accept          (req_fire),
		.kind            (req.kind),
		.index           (req.index),
		.count           (count_q),
		.found           (found_chain[CAPACITY]),
		.ctl             (ctl),
		.status          (status_d),
		.data_from_row   (data_from_row),
		.data_from_value (data_from_value),
		.count_d         (count_d)
	);

	// removed-by-value word equals the searched value
	always_comb begin
		data_w = '0;
		if (data_from_row)   data_w = rd_chain[CAPACITY];
		if (data_from_value) data_w = value_w;
	end

	// update the length on every accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (req_fire) begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (req_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// hold the result payload until the next item loads it
	always_ff @(posedge clk) begin
		if (req_fire) begin
			rsp_status_q <= status_d;
			rsp_data_q   <= rsp_data_d;
			rsp_count_q  <= rsp_count_d;
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.status = rsp_status_q;
	assign rsp.data   = rsp_data_q;
	assign rsp.count  = rsp_count_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("list length beyond capacity");

	a_error_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && (status_d != olir_pkg::STATUS_OK) |=> count_q == $past(count_q))
		else $error("failed request changed the length");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && (req.kind == olir_pkg::KIND_INSERT) && (status_d == olir_pkg::STATUS_OK)
		|=> count_q == CNT_W'($past(count_q) + 1'b1))
		else $error("insert did not grow the list by one");

	a_remove_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && (status_d == olir_pkg::STATUS_OK)
		&& ((req.kind == olir_pkg::KIND_REMOVE_AT) || (req.kind == olir_pkg::KIND_REMOVE_VAL))
		|=> count_q == CNT_W'($past(count_q) - 1'b1))
		else $error("removal did not shrink the list by one");

	a_result_follows_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> rsp_valid_q && (rsp_count_q == $past(rsp_count_d)))
		else $error("accepted item left no result");
`endif

endmodule

`default_nettype wire

FILE: sim/olir_checker.sv
// Scoreboard for the ordered list: watches the request and result channels,
// predicts each result from its own copy of the list, and counts mismatches.
// Depends on olir_pkg, olir_in_if and olir_out_if.
`timescale 1ns / 100ps

module olir_checker
	import olir_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	olir_in_if                  req,
	olir_out_if                 rsp,
	output int                  errors,
	output int                  pending,
	output logic [COUNT_W-1:0]  list_len
);

	typedef struct packed {
		status_t              status;
		logic [VALUE_W-1:0]   data;
		logic [COUNT_W-1:0]   count;
	} list_result_t;

	list_result_t        result_q[$];
	logic [VALUE_W-1:0]  words[CAPACITY];
	int unsigned         used;

	initial begin
		errors   = 0;
		pending  = 0;
		used     = 0;
		list_len = '0;
	end

	// Close the hole left at pos by moving every later entry down one place.
	function automatic void close_gap(input int unsigned pos);
		for (int unsigned i = pos; i + 1 < used; i++)
			words[i] = words[i + 1];
		used--;
	endfunction

	function automatic list_result_t apply_request(input logic [KIND_W-1:0] kind,
		input logic [INDEX_W-1:0] pos, input logic [VALUE_W-1:0] word);
		list_result_t r;
		r.status = STATUS_OK;
		r.data   = '0;
		case (kind)
			KIND_READ: begin
				if (pos < used)
					r.data = words[pos];
				else
					r.status = STATUS_RANGE;
			end
			KIND_WRITE: begin
				if (pos < used)
					words[pos] = word;
				else
					r.status = STATUS_RANGE;
			end
			KIND_INSERT: begin
				if (used >= CAPACITY) begin
					r.status = STATUS_FULL;
				end else if (pos > used) begin
					r.status = STATUS_RANGE;
				end else begin
					for (int unsigned i = used; i > pos; i--)
						words[i] = words[i - 1];
					words[pos] = word;
					used++;
				end
			end
			KIND_REMOVE_AT: begin
				if (pos < used) begin
					r.data = words[pos];
					close_gap(pos);
				end else begin
					r.status = STATUS_RANGE;
				end
			end
			KIND_REMOVE_VAL: begin
				r.status = STATUS_NOTFOUND;
				for (int unsigned i = 0; i < used; i++) begin
					if (words[i] == word) begin
						r.data   = words[i];
						r.status = STATUS_OK;
						close_gap(i);
						break;
					end
				end
			end
			default: ;
		endcase
		r.count = COUNT_W'(used);
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		$display("%0t ns  list mismatch: %s", $time, msg);
	endtask

	task automatic check_result();
		list_result_t want;
		if (result_q.size() == 0) begin
			report_mismatch($sformatf("result with no request outstanding (status %0d data %h)",
				rsp.status, rsp.data));
		end else begin
			want = result_q.pop_front();
			if (rsp.status !== want.status)
				report_mismatch($sformatf("status %0d, predicted %0d", rsp.status, want.status));
			if (rsp.data !== want.data)
				report_mismatch($sformatf("data %h, predicted %h", rsp.data, want.data));
			if (rsp.count !== want.count)
				report_mismatch($sformatf("count %0d, predicted %0d", rsp.count, want.count));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used = 0;
			result_q.delete();
		end else begin
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
				check_result();
			if (req.valid === 1'b1 && req.ready === 1'b1)
				result_q.push_back(apply_request(req.kind, req.index, req.value));
		end
		pending  = result_q.size();
		list_len = COUNT_W'(used);
	end

endmodule

FILE: sim/ordered_list_insert_remove_top_tb.sv
// Testbench top for the ordered list: clock, reset, request stimulus and
// result back-pressure; olir_checker does the prediction and comparison.
// Depends on olir_pkg, olir_in_if, olir_out_if, olir_checker and the block.
`timescale 1ns / 100ps

module ordered_list_insert_remove_top_tb;
	import olir_pkg::*;

	localparam int CAPACITY        = 16;
	localparam int ITEMS_PER_PHASE = 110;
	localparam int PHASES          = 16;
	localparam int PRESSURE_PHASE  = 4;
	localparam int HOLD_CYCLES     = 400;
	// About 1800 items in the slowest mix, plus the long hold; take that many
	// times over.
	localparam int LIMIT_CYCLES    = 300000;
	localparam int KIND_SPARE_LO   = int'(KIND_REMOVE_VAL) + 1;
	localparam int KIND_SPARE_HI   = 2 ** KIND_W - 1;

	// Kind mix of a phase: grow the list toward full, shrink it toward empty,
	// or keep it wandering around the middle.
	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} kind_mix_t;

	logic clk;
	logic arst_n;

	olir_in_if  req_ch ();
	olir_out_if rsp_ch ();

	int                 mismatches;
	int                 outstanding;
	logic [COUNT_W-1:0] list_len;

	int  send_idle_pct  = 0;
	int  recv_stall_pct = 0;
	bit  long_hold_req  = 1'b0;
	bit  long_hold_done = 1'b0;
	int  cycle_count    = 0;

	logic [VALUE_W-1:0] word_pool[8];

	ordered_list_insert_remove_top #(
		.CAPACITY  (CAPACITY),
		.DATA_WIDTH(VALUE_W)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	olir_checker #(
		.CAPACITY(CAPACITY)
	) u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.errors  (mismatches),
		.pending (outstanding),
		.list_len(list_len)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Result side. Stall at the rate of the current phase; once the long hold is
	// requested, drop ready for a fixed stretch so the result register stays
	// full and the block has to stall the sender, which keeps offering items.
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req && !long_hold_done) begin
				long_hold_done = 1'b1;
				repeat (HOLD_CYCLES) begin
					rsp_ch.ready <= 1'b0;
					@(posedge clk);
				end
			end
			rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Offer one item: idle first at the phase rate, then hold valid and the
	// fields until the block takes the item. Return at the accepting edge so the
	// next call can keep valid high without a dip.
	task automatic send_item(input logic [KIND_W-1:0] kind, input logic [INDEX_W-1:0] pos,
		input logic [VALUE_W-1:0] word);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind  <= kind;
		req_ch.index <= pos;
		req_ch.value <= word;
		@(posedge clk);
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
	endtask

	// Pick one random item. The length seen here may lag by one item; it only
	// steers indexes toward the live part of the list.
	task automatic pick_item(input kind_mix_t mix, output logic [KIND_W-1:0] kind,
		output logic [INDEX_W-1:0] pos, output logic [VALUE_W-1:0] word);
		int len;
		int roll;
		int w_ins, w_rat, w_rval, w_rd, w_wr;
		len  = list_len;
		roll = $urandom_range(0, 99);
		case (mix)
			MIX_FILL:  begin w_ins = 55; w_rat = 8;  w_rval = 7;  w_rd = 12; w_wr = 12; end
			MIX_DRAIN: begin w_ins = 15; w_rat = 30; w_rval = 30; w_rd = 10; w_wr = 10; end
			default:   begin w_ins = 25; w_rat = 18; w_rval = 17; w_rd = 17; w_wr = 18; end
		endcase
		if (roll < w_ins)
			kind = KIND_INSERT;
		else if (roll < w_ins + w_rat)
			kind = KIND_REMOVE_AT;
		else if (roll < w_ins + w_rat + w_rval)
			kind = KIND_REMOVE_VAL;
		else if (roll < w_ins + w_rat + w_rval + w_rd)
			kind = KIND_READ;
		else if (roll < w_ins + w_rat + w_rval + w_rd + w_wr)
			kind = KIND_WRITE;
		else
			kind = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));

		// Mostly a live position (insert may also append), sometimes the first
		// position past the end, sometimes anything.
		roll = $urandom_range(0, 99);
		if (roll < 70) begin
			if (kind == KIND_INSERT)
				pos = INDEX_W'($urandom_range(0, (len > 15) ? 15 : len));
			else
				pos = INDEX_W'($urandom_range(0, (len > 0) ? len - 1 : 0));
		end else if (roll < 80) begin
			pos = INDEX_W'((len > 15) ? 15 : len);
		end else begin
			pos = INDEX_W'($urandom_range(0, 15));
		end

		// Draw from a small pool so duplicates and remove-by-value hits are common.
		if ($urandom_range(0, 99) < 60)
			word = word_pool[$urandom_range(0, 7)];
		else
			word = $urandom;
	endtask

	initial begin
		logic [KIND_W-1:0]  kind;
		logic [INDEX_W-1:0] pos;
		logic [VALUE_W-1:0] word;
		int                 counted;

		arst_n        = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.kind  <= KIND_READ;
		req_ch.index <= '0;
		req_ch.value <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every request on an empty list, then inserts at front,
		// middle and end, reads and writes at and past the end, removal of a
		// duplicated value, a missing value, first and last positions, and the
		// unused kinds.
		send_item(KIND_READ,       4'd0,  '0);
		send_item(KIND_WRITE,      4'd0,  32'hDEAD_BEEF);
		send_item(KIND_REMOVE_AT,  4'd0,  '0);
		send_item(KIND_REMOVE_VAL, 4'd0,  '1);
		send_item(KIND_INSERT,     4'd1,  32'h1111_1111);
		send_item(KIND_INSERT,     4'd0,  '1);
		send_item(KIND_INSERT,     4'd0,  '0);
		send_item(KIND_INSERT,     4'd2,  32'hA5A5_A5A5);
		send_item(KIND_INSERT,     4'd1,  '0);
		send_item(KIND_INSERT,     4'd4,  '1);
		send_item(KIND_READ,       4'd0,  '0);
		send_item(KIND_READ,       4'd4,  '0);
		send_item(KIND_READ,       4'd5,  '0);
		send_item(KIND_READ,       4'd15, '0);
		send_item(KIND_WRITE,      4'd2,  32'h8000_0001);
		send_item(KIND_WRITE,      4'd5,  32'h5A5A_5A5A);
		send_item(KIND_REMOVE_VAL, 4'd0,  '0);
		send_item(KIND_REMOVE_VAL, 4'd0,  32'h1234_5678);
		send_item(KIND_REMOVE_AT,  4'd3,  '0);
		send_item(KIND_REMOVE_AT,  4'd0,  '0);
		send_item(KIND_REMOVE_AT,  4'd15, '0);
		for (int k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++)
			send_item(KIND_W'(k), INDEX_W'($urandom_range(0, 15)), $urandom);

		// Random phases: cycle the idle pattern and the kind mix independently so
		// every idle pattern meets a filling, a draining and a balanced list.
		for (int p = 0; p < PHASES; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
				default: begin send_idle_pct = 19; recv_stall_pct = 19; end
			endcase
			if (p == PRESSURE_PHASE)
				long_hold_req = 1'b1;
			foreach (word_pool[i])
				word_pool[i] = $urandom;
			if (p % 2 == 0) begin
				word_pool[0] = '0;
				word_pool[1] = '1;
			end
			counted = 0;
			while (counted < ITEMS_PER_PHASE) begin
				pick_item(kind_mix_t'(p % 3), kind, pos, word);
				send_item(kind, pos, word);
				// Unused kinds change nothing; leave them out of the tally.
				if (kind <= KIND_REMOVE_VAL)
					counted++;
			end
		end

		// Drain: stop offering, wait for the last results, then settle.
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/olir_pkg.sv
hw/rtl/olir_in_if.sv
hw/rtl/olir_out_if.sv
hw/rtl/olir_cell.sv
hw/rtl/olir_ctrl.sv
hw/rtl/ordered_list_insert_remove_top.sv
sim/olir_checker.sv
sim/ordered_list_insert_remove_top_tb.sv
